FILE: rtl/cas_pkg.sv
// cas_pkg: shared types and constants for the compacting array store.
// Used by cas_cell, compacting_array_store and cas_checker. No dependencies.
`default_nettype none

package cas_pkg;

    // Field widths fixed by the interface
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int CNT_W = 7;
    localparam int CAP_W = 8;
    localparam int CFG_W = 7;

    // Capacity after reset and its saturation ceiling
    localparam logic [CFG_W-1:0] CAP_RESET = 7'd5;
    localparam logic [CAP_W-1:0] CAP_MAX   = 8'hFF;

    // Register index of initial_capacity
    localparam logic REG_INIT_CAP = 1'b0;

    // Operation codes
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                    push;
        logic                    remove;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        pos;
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: rtl/cas_cell.sv
// cas_cell: one entry of the store, plus one stage of the read collection chain.
// Depends on cas_pkg.
`default_nettype none

module cas_cell #(
    parameter int FW  = 7,
    parameter int IDX = 0
) (
    input  wire                               i_clk,
    input  cas_pkg::t_cell_cmd                i_cmd,
    input  wire  [FW-1:0]                     i_fill,
    input  wire  signed [cas_pkg::VAL_W-1:0]  i_next,
    input  wire  signed [cas_pkg::VAL_W-1:0]  i_rd_prev,
    output logic signed [cas_pkg::VAL_W-1:0]  o_entry,
    output logic signed [cas_pkg::VAL_W-1:0]  o_rd
);

    localparam logic [FW-1:0]                  MY_IDX   = FW'(IDX);
    localparam logic [FW+cas_pkg::POS_W-1:0]   MY_IDX_X = (FW + cas_pkg::POS_W)'(IDX);

    logic signed [cas_pkg::VAL_W-1:0] r_entry;
    logic signed [cas_pkg::VAL_W-1:0] r_rd;
    logic [FW+cas_pkg::POS_W-1:0]     pos_x;
    logic                             hit_pos;

    assign pos_x   = {{FW{1'b0}}, i_cmd.pos};
    assign hit_pos = (MY_IDX_X == pos_x);

    // Entry: written by a push at the fill point, shifted down on a remove
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (i_fill == MY_IDX)) begin
            r_entry <= i_cmd.value;
        end else if (i_cmd.remove && (MY_IDX_X >= pos_x)) begin
            r_entry <= i_next;
        end
    end

    // Read chain: the selected entry enters here and moves up one cell a cycle
    always_ff @(posedge i_clk) begin
        r_rd <= hit_pos ? r_entry : i_rd_prev;
    end

    assign o_entry = r_entry;
    assign o_rd    = r_rd;

endmodule

`default_nettype wire

FILE: rtl/compacting_array_store.sv
// compacting_array_store: top level, control, configuration port and cell chain.
// Depends on cas_pkg and cas_cell.
//
// A packed array of DEPTH signed 32-bit entries held in a row of cells.
// Push and remove finish in the cycle the request is accepted: every cell
// decides for itself whether to load the new value or its upper neighbour's
// entry, so a remove compacts the whole array at once, and the result is
// ready in the output register on the next cycle. An accepted read walks
// the selected entry up the cell chain one cell per cycle, and the result is
// taken from the top cell at the end of the walk; a refused read finishes like
// a push. One request is in flight at a time, and a new request is taken
// while the previous result is being collected. Writing initial_capacity
// also reloads the current logical capacity.
`default_nettype none

module compacting_array_store #(
    parameter int DEPTH = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // request channel
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [1:0]                        i_op,
    input  wire  signed [cas_pkg::VAL_W-1:0]  i_value,
    input  wire  [cas_pkg::POS_W-1:0]         i_position,
    // result channel
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic                              o_accepted,
    output logic signed [cas_pkg::VAL_W-1:0]  o_read_value,
    output logic [cas_pkg::CNT_W-1:0]         o_count,
    output logic [cas_pkg::CAP_W-1:0]         o_logical_capacity,
    // configuration port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [2:0]                        paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int FW   = $clog2(DEPTH + 1);
    localparam int PW   = cas_pkg::POS_W;
    localparam int CW   = cas_pkg::CAP_W;
    localparam int NW   = cas_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    // state
    t_state                       r_state, n_state;
    logic [FW-1:0]                r_fill, n_fill;
    logic [CW-1:0]                r_cap, n_cap;
    logic [cas_pkg::CFG_W-1:0]    r_init_cap;
    logic [FW-1:0]                r_walk, n_walk;
    logic [PW-1:0]                r_pos, n_pos;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic                         r_acc, n_acc;
    logic signed [cas_pkg::VAL_W-1:0] r_rdv, n_rdv;
    logic [NW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                r_capo, n_capo;

    logic                         take;
    logic                         pos_ok;
    logic                         full;
    logic                         do_push, do_rem, do_read;
    logic [FW-1:0]                fill_inc;
    logic [CW:0]                  cap_dbl;
    logic [FW+NW-1:0]             cnt_x;
    logic                         cfg_wr;
    cas_pkg::t_cell_cmd           cmd;

    logic signed [cas_pkg::VAL_W-1:0] w_entry [DEPTH];
    logic signed [cas_pkg::VAL_W-1:0] w_rd    [DEPTH];

    // request decode
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;
    assign pos_ok     = {{FW{1'b0}}, i_position} < {{PW{1'b0}}, r_fill};
    assign full       = (r_fill == FW'(DEPTH));
    assign do_push    = take && (i_op == cas_pkg::OP_PUSH) && !full;
    assign do_rem     = take && (i_op == cas_pkg::OP_REMOVE) && pos_ok;
    assign do_read    = take && (i_op == cas_pkg::OP_READ) && pos_ok;
    assign fill_inc   = r_fill + 1'b1;
    assign cap_dbl    = {r_cap, 1'b0};

    // configuration write
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == cas_pkg::REG_INIT_CAP);

    // control and result
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cap       = r_cap;
        n_walk      = r_walk;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_acc       = r_acc;
        n_rdv       = r_rdv;
        n_cnt       = r_cnt;
        n_capo      = r_capo;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (do_push) begin
            n_fill = fill_inc;
            if ({{CW{1'b0}}, fill_inc} == {{FW{1'b0}}, r_cap}) begin
                n_cap = cap_dbl[CW] ? cas_pkg::CAP_MAX : cap_dbl[CW-1:0];
            end
        end else if (do_rem) begin
            n_fill = r_fill - 1'b1;
        end

        cnt_x = {{NW{1'b0}}, n_fill};

        case (r_state)
            ST_IDLE: begin
                if (do_read) begin
                    n_state = ST_READ;
                    n_pos   = i_position;
                    n_walk  = FW'(DEPTH);
                end else if (take) begin
                    n_out_valid = 1'b1;
                    n_acc       = do_push || do_rem;
                    n_rdv       = '0;
                    n_cnt       = cnt_x[NW-1:0];
                    n_capo      = n_cap;
                end
            end
            ST_READ: begin
                // wait for the selected entry to reach the end of the chain
                if (r_walk == '0) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_acc       = 1'b1;
                    n_rdv       = w_rd[DEPTH-1];
                    n_cnt       = cnt_x[NW-1:0];
                    n_capo      = r_cap;
                end else begin
                    n_walk = r_walk - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (cfg_wr) begin
            n_cap = {1'b0, pwdata[cas_pkg::CFG_W-1:0]};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_cap       <= {1'b0, cas_pkg::CAP_RESET};
            r_init_cap  <= cas_pkg::CAP_RESET;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cap       <= n_cap;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_init_cap <= pwdata[cas_pkg::CFG_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_acc  <= n_acc;
        r_rdv  <= n_rdv;
        r_cnt  <= n_cnt;
        r_capo <= n_capo;
    end

    // command to the chain; during a read walk the latched index selects
    always_comb begin
        cmd.push   = do_push;
        cmd.remove = do_rem;
        cmd.value  = i_value;
        cmd.pos    = (r_state == ST_READ) ? r_pos : i_position;
    end

    // cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [cas_pkg::VAL_W-1:0] next_entry;
        logic signed [cas_pkg::VAL_W-1:0] rd_prev;

        if (g == DEPTH - 1) begin : g_top
            assign next_entry = '0;
        end else begin : g_mid
            assign next_entry = w_entry[g+1];
        end

        if (g == 0) begin : g_first
            assign rd_prev = '0;
        end else begin : g_rest
            assign rd_prev = w_rd[g-1];
        end

        cas_cell #(
            .FW  (FW),
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cmd),
            .i_fill    (r_fill),
            .i_next    (next_entry),
            .i_rd_prev (rd_prev),
            .o_entry   (w_entry[g]),
            .o_rd      (w_rd[g])
        );
    end

    // register read-back
    assign prdata = (paddr[2] == cas_pkg::REG_INIT_CAP) ?
                    {{(32 - cas_pkg::CFG_W){1'b0}}, r_init_cap} : 32'd0;
    assign pready = 1'b1;

    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_acc;
    assign o_read_value       = r_rdv;
    assign o_count            = r_cnt;
    assign o_logical_capacity = r_capo;

endmodule

`default_nettype wire

FILE: rtl/cas_checker.sv
// cas_checker: port-level assertions for compacting_array_store, bound to the top.
// Depends on cas_pkg.
`default_nettype none

module cas_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_in_valid,
    input wire                               o_in_ready,
    input wire                               o_out_valid,
    input wire                               i_out_ready,
    input wire                               o_accepted,
    input wire signed [cas_pkg::VAL_W-1:0]   o_read_value,
    input wire [cas_pkg::CNT_W-1:0]          o_count,
    input wire [cas_pkg::CAP_W-1:0]          o_logical_capacity
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_accepted) && $stable(o_read_value) &&
            $stable(o_count) && $stable(o_logical_capacity))
        else $error("result changed while stalled");

    // no new request while a result is stuck in the output register
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while result stalled");

    // a refused request never returns data
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_read_value == '0)
        else $error("refused request returned data");

    // a request taken leaves the block busy or with a result the next cycle
    a_take_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid || !o_in_ready)
        else $error("request taken but block neither busy nor done");

endmodule

bind compacting_array_store cas_checker u_cas_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_accepted         (o_accepted),
    .o_read_value       (o_read_value),
    .o_count            (o_count),
    .o_logical_capacity (o_logical_capacity)
);

`default_nettype wire
